### design/cfb_pkg.sv
// Shared types and constants of the command frame builder.
// Used by the front, queue, back and top modules; no dependencies.
`timescale 1ns / 1ps
package cfb_pkg;

    localparam int MAX_PAYLOAD_DEF = 8;
    localparam int PAYLOAD_W       = 64;
    localparam int PAYLOAD_BYTES   = PAYLOAD_W / 8;
    localparam int LEN_W           = 4;
    localparam int POS_W           = 4;
    localparam int Q_DEPTH         = 2;
    localparam int Q_ADDR_W        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CMD_MAX    = 8'h11;
    localparam logic [7:0] CRC_POLY   = 8'h1D;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    localparam logic [POS_W-1:0] POS_MARKER    = 4'd0;
    localparam logic [POS_W-1:0] POS_COMMAND   = 4'd1;
    localparam logic [POS_W-1:0] POS_LEN       = 4'd2;
    localparam logic [POS_W-1:0] HDR_BYTES     = 4'd3;
    localparam logic [POS_W-1:0] FIXED_LAST    = 4'd3;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_USE_P1    = 2'd0;
    localparam logic [1:0] REG_MARKER_V1 = 2'd1;
    localparam logic [1:0] REG_MARKER_V2 = 2'd2;

    typedef struct packed {
        logic [7:0]           marker;
        logic [7:0]           command;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] data;
        logic                 crc_mode;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_rd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### design/cfb_front.sv
// Front end: accepts command items, rejects bad ones, builds frame descriptors.
// Depends on cfb_pkg.
`timescale 1ns / 1ps
module cfb_front #(
    parameter int MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          accept,
    input  logic [7:0]                    command,
    input  logic [7:0]                    payload_len,
    input  logic [cfb_pkg::PAYLOAD_W-1:0] payload,
    input  logic                          use_p1,
    input  logic [7:0]                    marker_v1,
    input  logic [7:0]                    marker_v2,
    output logic                          push,
    output cfb_pkg::desc_t                desc
);

    logic                          item_ok;
    logic [7:0]                    marker;
    logic [cfb_pkg::PAYLOAD_W-1:0] masked;

    always_comb
    begin
        item_ok = (command <= cfb_pkg::CMD_MAX) && (payload_len <= 8'(MAX_PAYLOAD));
        for (int k = 0; k < cfb_pkg::PAYLOAD_BYTES; k++)
        begin
            masked[8*k +: 8] = (8'(k) < payload_len) ? payload[8*k +: 8] : 8'h00;
        end
        marker = use_p1 ? marker_v1 : marker_v2;

        desc.marker   = marker;
        desc.command  = command;
        desc.len      = payload_len[cfb_pkg::LEN_W-1:0];
        desc.crc_mode = (marker == marker_v2);
        desc.data     = masked;
        // swap a two-byte payload: high byte first
        if (payload_len == 8'd2)
        begin
            desc.data[7:0]  = masked[15:8];
            desc.data[15:8] = masked[7:0];
        end
        push = accept && item_ok;
    end

endmodule

### design/cfb_queue.sv
// Short descriptor queue between front and back.
// Depends on cfb_pkg.
`timescale 1ns / 1ps
module cfb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cfb_pkg::desc_t    wr_desc,
    input  logic              pop,
    output cfb_pkg::q_rd_t    rd,
    output cfb_pkg::q_stat_t  stat
);

    cfb_pkg::desc_t                slot_reg [cfb_pkg::Q_DEPTH];
    logic [cfb_pkg::Q_ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cfb_pkg::Q_ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cfb_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    always_comb
    begin
        stat.full   = (count_reg == cfb_pkg::Q_CNT_W'(cfb_pkg::Q_DEPTH));
        stat.empty  = (count_reg == '0);
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        rd.valid    = !stat.empty;
        rd.desc     = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == cfb_pkg::Q_ADDR_W'(cfb_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cfb_pkg::Q_ADDR_W'(cfb_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

### design/cfb_back.sv
// Back end: byte sequencer that sends one frame per descriptor; running CRC-8, sent only in CRC mode.
// Depends on cfb_pkg.
`timescale 1ns / 1ps
module cfb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cfb_pkg::q_rd_t  rd,
    output logic            pop,
    output logic            active,
    output logic            out_valid,
    output logic [7:0]      out_byte,
    output logic            last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [cfb_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [cfb_pkg::POS_W-1:0]       last_pos_reg, last_pos_next;
    logic [7:0]                      crc_reg, crc_next;
    logic [7:0]                      marker_reg, marker_next;
    logic [7:0]                      cmd_reg, cmd_next;
    logic [cfb_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [cfb_pkg::PAYLOAD_W-1:0]   data_reg, data_next;
    logic                            crc_mode_reg, crc_mode_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_byte_reg, out_byte_next;
    logic                            last_reg, last_next;
    logic                            sending;
    logic                            is_last;
    logic                            load;
    logic                            shift;
    logic [7:0]                      cur_byte;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ cfb_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    always_comb
    begin
        sending  = (state_reg == ST_SEND);
        is_last  = sending && (pos_reg == last_pos_reg);
        load     = rd.valid && (!sending || is_last);
        shift    = 1'b0;
        cur_byte = data_reg[7:0];

        if (pos_reg == cfb_pkg::POS_MARKER)
        begin
            cur_byte = marker_reg;
        end
        else if (pos_reg == cfb_pkg::POS_COMMAND)
        begin
            cur_byte = cmd_reg;
        end
        else if (crc_mode_reg && pos_reg == cfb_pkg::POS_LEN)
        begin
            cur_byte = 8'(len_reg);
        end
        else if (crc_mode_reg && pos_reg == last_pos_reg)
        begin
            cur_byte = crc_reg ^ cfb_pkg::CRC_XOROUT;
        end
        else
        begin
            shift = 1'b1;
        end

        state_next     = state_reg;
        pos_next       = pos_reg;
        last_pos_next  = last_pos_reg;
        crc_next       = crc_reg;
        marker_next    = marker_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        data_next      = data_reg;
        crc_mode_next  = crc_mode_reg;
        out_valid_next = sending;
        out_byte_next  = cur_byte;
        last_next      = is_last;

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SEND:
            begin
                pos_next = pos_reg + 1'b1;
                crc_next = crc8_step(crc_reg, cur_byte);
                if (shift)
                begin
                    data_next = data_reg >> 8;
                end
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            state_next    = ST_SEND;
            pos_next      = '0;
            crc_next      = cfb_pkg::CRC_INIT;
            marker_next   = rd.desc.marker;
            cmd_next      = rd.desc.command;
            len_next      = rd.desc.len;
            data_next     = rd.desc.data;
            crc_mode_next = rd.desc.crc_mode;
            last_pos_next = rd.desc.crc_mode
                            ? cfb_pkg::HDR_BYTES + cfb_pkg::POS_W'(rd.desc.len)
                            : cfb_pkg::FIXED_LAST;
        end

        pop       = load;
        active    = sending;
        out_valid = out_valid_reg;
        out_byte  = out_byte_reg;
        last      = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            last_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            last_pos_reg  <= last_pos_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        marker_reg   <= marker_next;
        cmd_reg      <= cmd_next;
        len_reg      <= len_next;
        data_reg     <= data_next;
        crc_mode_reg <= crc_mode_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

### design/command_frame_builder_crc8_top.sv
// Command frame builder with CRC-8 SAE J1850: top level, APB registers, assertions.
// First byte of a frame: queue slot, then sequencer state, then out_byte register.
// Throughput: one byte per cycle; a frame is 4 + length bytes (4 for fixed
// framing), so the back byte sequencer sets how often a new item is taken.
// A two-entry queue takes start while a frame goes out; rejected items give no bytes.
// Reset clears registers, queue and sequencer at once; the receiver cannot stall.
`timescale 1ns / 1ps
module command_frame_builder_crc8_top #(
    parameter int MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    command,
    input  logic [7:0]                    payload_len,
    input  logic [cfb_pkg::PAYLOAD_W-1:0] payload,
    output logic                          out_valid,
    output logic [7:0]                    out_byte,
    output logic                          last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfb_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic               use_p1_reg, use_p1_next;
    logic [7:0]         marker_v1_reg, marker_v1_next;
    logic [7:0]         marker_v2_reg, marker_v2_next;
    logic               cfg_wr;
    logic [1:0]         reg_idx;
    logic               accept;
    logic               push;
    logic               pop;
    logic               back_active;
    cfb_pkg::desc_t     desc;
    cfb_pkg::q_rd_t     q_rd;
    cfb_pkg::q_stat_t   q_stat;

    always_comb
    begin
        pready         = 1'b1;
        cfg_wr         = psel && penable && pwrite && pready;
        reg_idx        = paddr[3:2];
        use_p1_next    = use_p1_reg;
        marker_v1_next = marker_v1_reg;
        marker_v2_next = marker_v2_reg;
        prdata         = '0;
        case (reg_idx)
            cfb_pkg::REG_USE_P1:
            begin
                prdata = 32'(use_p1_reg);
                if (cfg_wr)
                begin
                    use_p1_next = pwdata[0];
                end
            end
            cfb_pkg::REG_MARKER_V1:
            begin
                prdata = 32'(marker_v1_reg);
                if (cfg_wr)
                begin
                    marker_v1_next = pwdata[7:0];
                end
            end
            cfb_pkg::REG_MARKER_V2:
            begin
                prdata = 32'(marker_v2_reg);
                if (cfg_wr)
                begin
                    marker_v2_next = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
        busy   = q_stat.full;
        accept = start && !busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_p1_reg    <= 1'b0;
            marker_v1_reg <= 8'h00;
            marker_v2_reg <= 8'h00;
        end
        else
        begin
            use_p1_reg    <= use_p1_next;
            marker_v1_reg <= marker_v1_next;
            marker_v2_reg <= marker_v2_next;
        end
    end

    cfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .accept      (accept),
        .command     (command),
        .payload_len (payload_len),
        .payload     (payload),
        .use_p1      (use_p1_reg),
        .marker_v1   (marker_v1_reg),
        .marker_v2   (marker_v2_reg),
        .push        (push),
        .desc        (desc)
    );

    cfb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (desc),
        .pop     (pop),
        .rd      (q_rd),
        .stat    (q_stat)
    );

    cfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (q_rd),
        .pop       (pop),
        .active    (back_active),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
        else $error("frame bytes not contiguous");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (!q_stat.empty || back_active))
        else $error("accepted item lost");

    a_pending_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty && !back_active |=> back_active)
        else $error("queued item not started");

    a_last_ends_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !$past(pop) |-> !back_active)
        else $error("sequencer still active after last byte");
`endif

endmodule

### test/command_frame_builder_crc8_top_test.sv
// Testbench of command_frame_builder_crc8_top: directed and random command items.
// Predicts each framed byte stream and checks it byte by byte.
// Depends on cfb_pkg and the design top level.
`timescale 1ns / 1ps
module command_frame_builder_crc8_top_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 27;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [7:0]                    command;
    logic [7:0]                    payload_len;
    logic [cfb_pkg::PAYLOAD_W-1:0] payload;
    logic                          out_valid;
    logic [7:0]                    out_byte;
    logic                          last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [cfb_pkg::ADDR_W-1:0]    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    logic       cfg_use_p1;
    logic [7:0] cfg_marker_v1;
    logic [7:0] cfg_marker_v2;

    logic [7:0] frame_byte_q[$];
    logic       frame_last_q[$];
    int         mismatch_count;
    int         quiet_cycles;
    int         idle_pct;

    command_frame_builder_crc8_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .payload_len (payload_len),
        .payload     (payload),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] crc8_j1850_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ cfb_pkg::CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void predict_frame(input logic [7:0] cmd, input logic [7:0] len,
                                          input logic [cfb_pkg::PAYLOAD_W-1:0] pl);
        logic [7:0] data [cfb_pkg::PAYLOAD_BYTES];
        logic [7:0] frame [4 + cfb_pkg::PAYLOAD_BYTES];
        logic [7:0] marker;
        logic [7:0] crc;
        logic [7:0] swap;
        int         n;
        if (cmd > cfb_pkg::CMD_MAX || len > cfb_pkg::MAX_PAYLOAD_DEF)
            return;
        for (int k = 0; k < cfb_pkg::PAYLOAD_BYTES; k++)
            data[k] = (k < len) ? pl[8*k +: 8] : 8'h00;
        if (len == 8'd2)
        begin
            swap    = data[0];
            data[0] = data[1];
            data[1] = swap;
        end
        marker   = cfg_use_p1 ? cfg_marker_v1 : cfg_marker_v2;
        frame[0] = marker;
        frame[1] = cmd;
        if (marker == cfg_marker_v2)
        begin
            frame[2] = len;
            for (int k = 0; k < len; k++)
                frame[3 + k] = data[k];
            crc = cfb_pkg::CRC_INIT;
            for (int k = 0; k < 3 + len; k++)
                crc = crc8_j1850_step(crc, frame[k]);
            frame[3 + len] = crc ^ cfb_pkg::CRC_XOROUT;
            n = 4 + len;
        end
        else
        begin
            frame[2] = data[0];
            frame[3] = data[1];
            n = 4;
        end
        for (int k = 0; k < n; k++)
        begin
            frame_byte_q.push_back(frame[k]);
            frame_last_q.push_back(k == n - 1);
        end
    endfunction

    always @(posedge clk)
    begin
        logic [7:0] exp_byte;
        logic       exp_last;
        if (rst_n && out_valid)
        begin
            if (frame_byte_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual byte %02h last %0b",
                         $time, out_byte, last);
                mismatch_count++;
            end
            else
            begin
                exp_byte = frame_byte_q.pop_front();
                exp_last = frame_last_q.pop_front();
                if (out_byte !== exp_byte)
                begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, exp_byte, out_byte);
                    mismatch_count++;
                end
                if (last !== exp_last)
                begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, exp_last, last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_valid || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("command_frame_builder_crc8_top_test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] cmd, input logic [7:0] len,
                             input logic [cfb_pkg::PAYLOAD_W-1:0] pl);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        payload_len <= len;
        payload     <= pl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_frame(cmd, len, pl);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (frame_byte_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            cfb_pkg::REG_USE_P1:    cfg_use_p1    = value[0];
            cfb_pkg::REG_MARKER_V1: cfg_marker_v1 = value[7:0];
            cfb_pkg::REG_MARKER_V2: cfg_marker_v2 = value[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [31:0] exp_value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== exp_value)
        begin
            $display("%0t: register %0d readback mismatch, expected %08h, actual %08h",
                     $time, idx, exp_value, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic use_p1, input logic [7:0] m1, input logic [7:0] m2);
        apb_write(cfb_pkg::REG_USE_P1, {31'd0, use_p1});
        apb_write(cfb_pkg::REG_MARKER_V1, {24'd0, m1});
        apb_write(cfb_pkg::REG_MARKER_V2, {24'd0, m2});
    endtask

    task automatic test_reset_markers;
        idle_pct = 20;
        send_item(8'h00, 8'd0, 64'h0);
        send_item(8'h11, 8'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(8'h05, 8'd2, 64'hFFFF_FFFF_FFFF_A55A);
        send_item(8'h12, 8'd1, 64'h1);
        send_item(8'hFF, 8'd0, 64'h0);
        send_item(8'h01, 8'd9, 64'h0123_4567_89AB_CDEF);
        send_item(8'h02, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(8'h0A, 8'd5, 64'hDEAD_BEEF_CAFE_F00D);
        drain();
    endtask

    task automatic test_register_access;
        apb_write(cfb_pkg::REG_USE_P1, 32'hFFFF_FFFF);
        apb_write(cfb_pkg::REG_MARKER_V1, 32'hFFFF_FFA5);
        apb_write(cfb_pkg::REG_MARKER_V2, 32'h0000_005A);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        apb_check(cfb_pkg::REG_USE_P1, 32'h0000_0001);
        apb_check(cfb_pkg::REG_MARKER_V1, 32'h0000_00A5);
        apb_check(cfb_pkg::REG_MARKER_V2, 32'h0000_005A);
    endtask

    task automatic test_fixed_frames;
        idle_pct = 0;
        send_item(8'h00, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(8'h11, 8'd1, 64'hFFFF_FFFF_FFFF_FF3C);
        send_item(8'h07, 8'd2, 64'h0000_0000_0000_1234);
        send_item(8'h08, 8'd8, 64'h8877_6655_4433_2211);
        send_item(8'h13, 8'd2, 64'h1);
        send_item(8'h03, 8'd3, 64'h00FF_FF00_0000_8001);
        drain();
    endtask

    task automatic test_equal_markers;
        set_config(1'b1, 8'hFF, 8'hFF);
        idle_pct = 85;
        send_item(8'h04, 8'd2, 64'h0000_0000_0000_00FF);
        send_item(8'h10, 8'd3, 64'hFFFF_FFFF_FF00_7F80);
        send_item(8'h11, 8'd8, 64'h0);
        drain();
        set_config(1'b0, 8'h00, 8'hFF);
        send_item(8'h00, 8'd0, 64'h0);
        send_item(8'h09, 8'd8, 64'hFEDC_BA98_7654_3210);
        drain();
    endtask

    task automatic test_random_traffic;
        logic [7:0]                    cmd;
        logic [7:0]                    len;
        logic [cfb_pkg::PAYLOAD_W-1:0] pl;
        logic [7:0]                    m1;
        int                            pcts[6];
        pcts = '{20, 20, 85, 85, 0, 0};
        for (int phase = 0; phase < 6; phase++)
        begin
            m1 = 8'($urandom_range(0, 255));
            set_config(1'($urandom_range(0, 1)), m1,
                       ($urandom_range(0, 3) == 0) ? m1 : 8'($urandom_range(0, 255)));
            idle_pct = pcts[phase];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                cmd = 8'($urandom_range(0, cfb_pkg::CMD_MAX));
                len = 8'($urandom_range(0, cfb_pkg::MAX_PAYLOAD_DEF));
                pl  = {$urandom, $urandom};
                case ($urandom_range(0, 19))
                    0:       cmd = 8'($urandom_range(cfb_pkg::CMD_MAX + 1, 255));
                    1:       len = 8'($urandom_range(cfb_pkg::MAX_PAYLOAD_DEF + 1, 255));
                    2:
                    begin
                        cmd = 8'($urandom_range(0, 255));
                        len = 8'($urandom_range(0, 255));
                    end
                    default: ;
                endcase
                send_item(cmd, len, pl);
            end
            drain();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = 8'h00;
        payload_len    = 8'h00;
        payload        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = 32'h0;
        cfg_use_p1     = 1'b0;
        cfg_marker_v1  = 8'h00;
        cfg_marker_v2  = 8'h00;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_pct       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_markers();
        test_register_access();
        test_fixed_frames();
        test_equal_markers();
        test_random_traffic();

        drain();
        if (mismatch_count == 0 && frame_byte_q.size() == 0)
            $display("command_frame_builder_crc8_top_test passed");
        else
            $display("command_frame_builder_crc8_top_test failed");
        $finish;
    end
endmodule
